/* design/bslp_pkg.sv */
// bslp_pkg: shared types and constants of the button press detector
// no dependencies; used by every module in design/

package bslp_pkg;

	// default counter width of the tick timers
	localparam int TIMER_BITS_DEF = 16;

	// configuration register file
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_LIMIT = 1'b1;

	// reset values of the registers
	localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST    = 16'd10;
	localparam logic [CFG_W-1:0] LONG_PRESS_LIMIT_RST = 16'd1000;

	// press state machine
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_PRESSED = 3'd1,
		PH_SHORT   = 3'd2,
		PH_LONG    = 3'd3,
		PH_WAIT    = 3'd4
	} phase_t;

	// input stage contents
	typedef struct packed {
		logic valid;
		logic button_level;
	} s1_t;

	// result word of one tick
	typedef struct packed {
		logic click_event;
		logic short_press_event;
		logic long_press_event;
		logic sample_taken;
	} res_t;

endpackage

/* design/bslp_ifs.sv */
// bslp_ifs: valid/ready channel interfaces of the button press detector
// depends on nothing; instantiated around button_short_long_press_detector_unit

// tick channel: one word per tick carrying the sampled button level
interface bslp_tick_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink   (input valid, input button_level, output ready);
endinterface

// event channel: one result word per tick
interface bslp_event_if;
	logic valid;
	logic ready;
	logic click_event;
	logic short_press_event;
	logic long_press_event;
	logic sample_taken;

	modport source (output valid, output click_event, output short_press_event,
		output long_press_event, output sample_taken, input ready);
	modport sink   (input valid, input click_event, input short_press_event,
		input long_press_event, input sample_taken, output ready);
endinterface

/* design/button_short_long_press_detector_unit.sv */
// button_short_long_press_detector_unit: short/long press detector top level
// depends on bslp_pkg, bslp_ifs, bslp_in_stage, bslp_step, bslp_out_stage
//
// Usage: every word on the button channel is one time tick carrying the
// sampled level of an active-low button (0 pressed). For each tick word one
// event word leaves on the events channel with click, short press, long press
// and sample-taken flags. Registers sample_period (index 0) and
// long_press_limit (index 1) are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; it is not enforced.
// Pipeline: an accepted tick word passes two register stages, the input
// register and then the result register, before its event word shows.
// Throughput: one word per cycle while events.ready stays high; the counters
// and the five-state machine update in the single logic stage in between.
// Reset: arst_n clears both stages, the counters and the state machine and
// loads the register defaults (10 and 1000).
// Stall: while the events receiver holds ready low the result register keeps
// its word, the input register still takes one more tick word, and then
// button.ready drops until the result word is taken.

module button_short_long_press_detector_unit #(
	parameter int TIMER_BITS = bslp_pkg::TIMER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bslp_tick_if.sink                       button,
	bslp_event_if.source                    events,
	input  logic                            cfg_we,
	input  logic [bslp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bslp_pkg::CFG_W-1:0]      cfg_data
);

	logic [bslp_pkg::CFG_W-1:0] sample_period_q;
	logic [bslp_pkg::CFG_W-1:0] long_press_limit_q;
	bslp_pkg::s1_t              s1;
	bslp_pkg::res_t             res;
	logic                       advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q    <= bslp_pkg::SAMPLE_PERIOD_RST;
			long_press_limit_q <= bslp_pkg::LONG_PRESS_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bslp_pkg::CFG_SAMPLE_PERIOD:    sample_period_q    <= cfg_data;
				bslp_pkg::CFG_LONG_PRESS_LIMIT: long_press_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	bslp_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (button),
		.advance (advance),
		.s1      (s1)
	);

	// counters and state machine
	bslp_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.clk              (clk),
		.arst_n           (arst_n),
		.s1               (s1),
		.advance          (advance),
		.sample_period    (sample_period_q),
		.long_press_limit (long_press_limit_q),
		.res              (res)
	);

	// result register
	bslp_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1.valid),
		.res      (res),
		.events   (events),
		.advance  (advance)
	);

	// at most one press event per word
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> $countones({events.click_event, events.short_press_event,
			events.long_press_event}) <= 1)
		else $error("more than one press event in a word");

	// events only on ticks where the machine stepped
	a_event_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && (events.click_event || events.short_press_event
			|| events.long_press_event)) |-> events.sample_taken)
		else $error("press event without a sample step");

	// the tick channel only stalls when both stages are full and the output waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!button.ready |-> (s1.valid && events.valid && !events.ready))
		else $error("tick channel stalled without a full pipeline");

	// a word moving out of the input register shows up as a result next cycle
	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> events.valid)
		else $error("advanced word missing from result register");

endmodule

/* design/bslp_in_stage.sv */
// bslp_in_stage: input register of the tick channel
// depends on bslp_pkg and bslp_tick_if

module bslp_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	bslp_tick_if.sink        tick,
	input  logic             advance,
	output bslp_pkg::s1_t    s1
);

	logic valid_s1;
	logic level_s1;

	// stage is free when empty or when its word moves on this cycle
	assign tick.ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			level_s1 <= tick.button_level;
		end
	end

	assign s1.valid        = valid_s1;
	assign s1.button_level = level_s1;

endmodule

/* design/bslp_step.sv */
// bslp_step: tick counters updated per word, press state machine stepped on each sample
// depends on bslp_pkg

module bslp_step #(
	parameter int TIMER_BITS = bslp_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bslp_pkg::s1_t                 s1,
	input  logic                          advance,
	input  logic [bslp_pkg::CFG_W-1:0]    sample_period,
	input  logic [bslp_pkg::CFG_W-1:0]    long_press_limit,
	output bslp_pkg::res_t                res
);

	localparam int CMP_W = (TIMER_BITS > bslp_pkg::CFG_W) ? TIMER_BITS : bslp_pkg::CFG_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

	bslp_pkg::phase_t        phase_q, phase_d;
	logic [TIMER_BITS-1:0]   tss_q, tss_d, tss_inc;
	logic [TIMER_BITS-1:0]   tsp_q, tsp_d, tsp_inc;
	logic                    step;
	logic                    released;

	// state registers, updated as the word moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bslp_pkg::PH_IDLE;
			tss_q   <= '0;
			tsp_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			tss_q   <= tss_d;
			tsp_q   <= tsp_d;
		end
	end

	// saturating increments and sample compare
	assign tss_inc  = (tss_q == CNT_MAX) ? tss_q : tss_q + 1'b1;
	assign tsp_inc  = (tsp_q == CNT_MAX) ? tsp_q : tsp_q + 1'b1;
	assign step     = CMP_W'(tss_inc) >= CMP_W'(sample_period);
	assign released = s1.button_level;

	// next state and events
	always_comb begin
		phase_d = phase_q;
		tss_d   = step ? '0 : tss_inc;
		tsp_d   = tsp_inc;
		res     = '0;
		if (step) begin
			res.sample_taken = 1'b1;
			unique case (phase_q)
				bslp_pkg::PH_IDLE: begin
					if (!released) begin
						res.click_event = 1'b1;
						phase_d         = bslp_pkg::PH_PRESSED;
						tsp_d           = '0;
					end
				end
				bslp_pkg::PH_PRESSED: begin
					if (CMP_W'(tsp_inc) < CMP_W'(long_press_limit)) begin
						if (released) begin
							phase_d = bslp_pkg::PH_SHORT;
						end
					end else begin
						phase_d = bslp_pkg::PH_LONG;
					end
				end
				bslp_pkg::PH_SHORT: begin
					res.short_press_event = 1'b1;
					phase_d               = bslp_pkg::PH_IDLE;
				end
				bslp_pkg::PH_LONG: begin
					res.long_press_event = 1'b1;
					phase_d              = bslp_pkg::PH_WAIT;
				end
				bslp_pkg::PH_WAIT: begin
					if (released) begin
						phase_d = bslp_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = bslp_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/bslp_out_stage.sv */
// bslp_out_stage: result register of the event channel
// depends on bslp_pkg and bslp_event_if

module bslp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	input  bslp_pkg::res_t   res,
	bslp_event_if.source     events,
	output logic             advance
);

	logic           valid_s2;
	bslp_pkg::res_t res_s2;

	// the input stage word moves when the result register is free or drains
	assign advance = s1_valid && (!valid_s2 || events.ready);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (events.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign events.valid             = valid_s2;
	assign events.click_event       = res_s2.click_event;
	assign events.short_press_event = res_s2.short_press_event;
	assign events.long_press_event  = res_s2.long_press_event;
	assign events.sample_taken      = res_s2.sample_taken;

endmodule
